>>> hw/rtl/pci_pkg.sv
// ----------------------------------------------------------------------------
// Pulse charge integrator package
// Shared widths, limits, register codes and the frame snapshot type.
// ----------------------------------------------------------------------------
package pci_pkg;

  // Frame and store geometry.
  localparam int MAX_FRAME        = 4096;
  localparam int PREFIX_DEPTH     = 256;
  localparam int PEDESTAL_DIVISOR = 20;

  // Field widths.
  localparam int TIME_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int THR_W      = 16;
  localparam int SCALE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int CHARGE_W   = 48;
  localparam int HEIGHT_W   = 17;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Derived widths.
  localparam int CNT_W  = $clog2(MAX_FRAME + 1);
  localparam int SUM_W  = CNT_W + SAMPLE_W;
  localparam int PFX_AW = $clog2(PREFIX_DEPTH);
  localparam int PFX_W  = PFX_AW + SAMPLE_W;
  localparam int DIV_W  = $clog2(PEDESTAL_DIVISOR + 1);
  localparam int DIFF_W = ((SUM_W > PFX_W + DIV_W) ? SUM_W : PFX_W + DIV_W) + 1;
  localparam int PROD_W = DIFF_W + SCALE_W + 1;

  // Division of the frame length by the pedestal divisor is done as a
  // multiply by a rounded-up reciprocal; the error stays below one part in
  // the divisor for every count the counter can hold.
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << RECIP_SHIFT) + PEDESTAL_DIVISOR - 1) / PEDESTAL_DIVISOR);

  localparam logic [CNT_W-1:0] NO_DEPARTURE = '1;

  // Register reset values.
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(2621);
  localparam logic [SCALE_W-1:0] SCALE_RESET     = SCALE_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_THRESHOLD = 1'b0,
    REG_CHARGE_SCALE   = 1'b1
  } cfg_reg_t;

  // Everything the charge stage needs from a frame that has just closed.
  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic signed [SAMPLE_W-1:0] minimum;
    logic [CNT_W-1:0]           first_departure;
    logic [PFX_AW-1:0]          pedestal_len;
    logic                       too_long;
  } frame_snap_t;

endpackage

>>> hw/rtl/pci_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one timestamped digitizer sample per beat.
// ----------------------------------------------------------------------------
interface pci_sample_if;
  import pci_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [TIME_W-1:0]          sample_time;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_time, output sample_value, input ready);
  modport sink   (input valid, input sample_time, input sample_value, output ready);
endinterface

>>> hw/rtl/pci_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one closed-frame result per beat.
// ----------------------------------------------------------------------------
interface pci_result_if;
  import pci_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [CHARGE_W-1:0] charge;
  logic signed [HEIGHT_W-1:0] pulse_height;
  logic                       frame_skipped;
  logic                       frame_too_long;

  modport source (output valid, output charge, output pulse_height,
                  output frame_skipped, output frame_too_long, input ready);
  modport sink   (input valid, input charge, input pulse_height,
                  input frame_skipped, input frame_too_long, output ready);
endinterface

>>> hw/rtl/pci_frame.sv
// ----------------------------------------------------------------------------
// Frame tracker
// Input register, running frame state, prefix-sum memory and the snapshot
// register that hands a closed frame to the charge stage.
// ----------------------------------------------------------------------------
module pci_frame (
  input  logic                                 clk,
  input  logic                                 rst,
  pci_sample_if.sink                           samples,
  input  logic [pci_pkg::THR_W-1:0]            peak_threshold,
  input  logic                                 snap_free,
  output logic                                 snap_valid,
  output pci_pkg::frame_snap_t                 snap,
  output logic signed [pci_pkg::PFX_W-1:0]     pedestal_sum
);
  import pci_pkg::*;

  localparam int NV_W   = CNT_W + SAMPLE_W + 1;
  localparam int DEV_W  = NV_W + 1;
  localparam int LIM_W  = THR_W + CNT_W;
  localparam int PED_PW = CNT_W + RECIP_W;
  localparam int PED_QW = PED_PW - RECIP_SHIFT;

  // Input register.
  logic                       in_valid;
  logic [TIME_W-1:0]          in_time;
  logic signed [SAMPLE_W-1:0] in_value;

  // Frame state.
  logic                       seen;
  logic [TIME_W-1:0]          prev_time;
  logic [CNT_W-1:0]           count;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] minimum;
  logic [CNT_W-1:0]           first_dep;
  logic                       too_long;

  logic signed [PFX_W-1:0] prefix_mem [PREFIX_DEPTH];

  logic                       later, opening, closing, fire, snap_load, full, departs;
  logic [CNT_W-1:0]           base_cnt, cnt_next, base_dep, dep_next;
  logic signed [SUM_W-1:0]    base_sum, sum_next;
  logic signed [SAMPLE_W-1:0] base_min, min_next;
  logic signed [NV_W-1:0]     prod_nv;
  logic signed [DEV_W-1:0]    dev;
  logic [DEV_W-1:0]           dev_mag;
  logic [LIM_W-1:0]           limit;
  logic                       pfx_we;
  logic [PED_PW-1:0]          ped_prod;
  logic [PED_QW-1:0]          ped_full;
  logic [PFX_AW-1:0]          ped_len;

  assign later     = in_time > prev_time;
  assign opening   = !seen || !later;
  assign closing   = seen && !later;
  assign fire      = in_valid && (!closing || !snap_valid || snap_free);
  assign snap_load = fire && closing;

  assign samples.ready = !in_valid || fire;

  // A new frame starts from cleared state; the sample is then accumulated.
  assign base_cnt = opening ? '0 : count;
  assign base_sum = opening ? '0 : sum;
  assign base_min = opening ? SAMPLE_W'(16'sh7FFF) : minimum;
  assign base_dep = opening ? NO_DEPARTURE : first_dep;

  // Departure test: |n*v - sum| > threshold*n, only against a running frame.
  assign prod_nv = $signed({1'b0, count}) * in_value;
  assign dev     = DEV_W'(prod_nv) - DEV_W'(sum);
  assign dev_mag = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
  assign limit   = LIM_W'(peak_threshold) * LIM_W'(count);
  assign departs = !opening && (count != '0) && (first_dep == NO_DEPARTURE) &&
                   (dev_mag > DEV_W'(limit));

  assign full     = !opening && (count >= CNT_W'(MAX_FRAME));
  assign cnt_next = base_cnt + CNT_W'(1);
  assign sum_next = base_sum + SUM_W'(in_value);
  assign min_next = (in_value < base_min) ? in_value : base_min;
  assign dep_next = departs ? (count - CNT_W'(1)) : base_dep;
  assign pfx_we   = fire && !full && (cnt_next < CNT_W'(PREFIX_DEPTH));

  // Pedestal length of the frame being closed.
  assign ped_prod = PED_PW'(count) * PED_PW'(RECIP);
  assign ped_full = ped_prod[PED_PW-1:RECIP_SHIFT];
  assign ped_len  = (ped_full > PED_QW'(PREFIX_DEPTH - 1)) ?
                    PFX_AW'(PREFIX_DEPTH - 1) : ped_full[PFX_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (samples.ready) begin
      in_valid <= samples.valid;
    end
    if (samples.valid && samples.ready) begin
      in_time  <= samples.sample_time;
      in_value <= samples.sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= 1'b0;
      prev_time <= '0;
      count     <= '0;
      sum       <= '0;
      minimum   <= SAMPLE_W'(16'sh7FFF);
      first_dep <= NO_DEPARTURE;
      too_long  <= 1'b0;
    end else if (fire) begin
      seen      <= 1'b1;
      prev_time <= in_time;
      too_long  <= full || (!opening && too_long);
      if (!full) begin
        count     <= cnt_next;
        sum       <= sum_next;
        minimum   <= min_next;
        first_dep <= dep_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (snap_load) begin
      snap_valid <= 1'b1;
    end else if (snap_free) begin
      snap_valid <= 1'b0;
    end
    if (snap_load) begin
      snap.sum             <= sum;
      snap.minimum         <= minimum;
      snap.first_departure <= first_dep;
      snap.pedestal_len    <= ped_len;
      snap.too_long        <= too_long;
    end
  end

  // Entry zero is never stored; the charge stage treats it as zero.
  always_ff @(posedge clk) begin
    if (pfx_we) begin
      prefix_mem[cnt_next[PFX_AW-1:0]] <= sum_next[PFX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (snap_load) begin
      pedestal_sum <= prefix_mem[ped_len];
    end
  end

endmodule

>>> hw/rtl/pci_charge.sv
// ----------------------------------------------------------------------------
// Charge calculator
// Pedestal subtraction, scaling multiply and result register for one
// closed frame per beat.
// ----------------------------------------------------------------------------
module pci_charge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              snap_valid,
  input  pci_pkg::frame_snap_t              snap,
  input  logic signed [pci_pkg::PFX_W-1:0]  pedestal_sum,
  input  logic [pci_pkg::SCALE_W-1:0]       charge_scale,
  output logic                              snap_free,
  pci_result_if.source                      results
);
  import pci_pkg::*;

  localparam int SHIFT_W = PROD_W - FRAC_W;
  localparam int QX_W    = ((SHIFT_W > CHARGE_W) ? SHIFT_W : CHARGE_W) + 1;
  localparam logic signed [QX_W-1:0] CHG_MAX = (QX_W'(1) <<< (CHARGE_W - 1)) - QX_W'(1);
  localparam logic signed [QX_W-1:0] CHG_MIN = -(QX_W'(1) <<< (CHARGE_W - 1));

  // Stage 1: negated pedestal-subtracted sum.
  logic                       k1_valid;
  logic signed [DIFF_W-1:0]   k1_neg_diff;
  logic                       k1_skipped;
  logic signed [HEIGHT_W-1:0] k1_height;
  logic                       k1_too_long;

  // Stage 2: scaled product.
  logic                       k2_valid;
  logic signed [PROD_W-1:0]   k2_prod;
  logic                       k2_skipped;
  logic signed [HEIGHT_W-1:0] k2_height;
  logic                       k2_too_long;

  logic                       out_free, k2_free, k1_free;
  logic signed [PFX_W-1:0]    ped_val;
  logic signed [DIFF_W-1:0]   diff;
  logic                       skipped;
  logic signed [QX_W-1:0]     qx;
  logic signed [CHARGE_W-1:0] charge_sat;

  assign out_free  = !results.valid || results.ready;
  assign k2_free   = !k2_valid || out_free;
  assign k1_free   = !k1_valid || k2_free;
  assign snap_free = k1_free;

  assign ped_val = (snap.pedestal_len == '0) ? '0 : pedestal_sum;
  assign diff    = DIFF_W'($signed(snap.sum)) -
                   $signed(DIFF_W'(PEDESTAL_DIVISOR)) * DIFF_W'(ped_val);
  assign skipped = snap.first_departure < CNT_W'(snap.pedestal_len);

  // Floor division by 2^FRAC_W is an arithmetic shift.
  assign qx = QX_W'($signed(k2_prod[PROD_W-1:FRAC_W]));
  assign charge_sat = (qx > CHG_MAX) ? CHG_MAX[CHARGE_W-1:0] :
                      (qx < CHG_MIN) ? CHG_MIN[CHARGE_W-1:0] : qx[CHARGE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      k1_valid <= 1'b0;
    end else if (k1_free) begin
      k1_valid <= snap_valid;
    end
    if (k1_free && snap_valid) begin
      k1_neg_diff <= -diff;
      k1_skipped  <= skipped;
      k1_height   <= -HEIGHT_W'($signed(snap.minimum));
      k1_too_long <= snap.too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k2_valid <= 1'b0;
    end else if (k2_free) begin
      k2_valid <= k1_valid;
    end
    if (k2_free && k1_valid) begin
      k2_prod     <= k1_skipped ? '0 :
                     PROD_W'(k1_neg_diff) * PROD_W'($signed({1'b0, charge_scale}));
      k2_skipped  <= k1_skipped;
      k2_height   <= k1_height;
      k2_too_long <= k1_too_long;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= k2_valid;
    end
    if (out_free && k2_valid) begin
      results.charge         <= charge_sat;
      results.pulse_height   <= k2_height;
      results.frame_skipped  <= k2_skipped;
      results.frame_too_long <= k2_too_long;
    end
  end

endmodule

>>> hw/rtl/pulse_charge_integrator_core.sv
// ----------------------------------------------------------------------------
// Pulse charge integrator core
// Pedestal-subtracted charge and pulse height of timestamped sample frames.
// ----------------------------------------------------------------------------
// The block takes one digitizer sample per beat and sustains one beat per
// clock unless a frame closes onto a full snapshot register. A sample whose
// timestamp is not greater than the one before closes the running frame and
// starts the next; its result passes through the input register, snapshot
// register with its prefix-memory read, subtraction stage, 32-bit scaling
// multiplier and result register. Each stage holds its beat while the one
// after it is full, so samples keep flowing while a result waits to be taken,
// and up to four results can be in flight. The prefix-sum memory (256 x 24)
// needs no clearing after reset, so the first sample may be sent in the first
// cycle out of reset. The last frame is reported only once a later sample
// closes it. The user writes configuration through cfg_write_en, cfg_index
// and cfg_data only while no beat is in flight, unchecked by the block.
// ----------------------------------------------------------------------------
module pulse_charge_integrator_core (
  input  logic                               clk,
  input  logic                               rst,
  pci_sample_if.sink                         samples,
  pci_result_if.source                       results,
  input  logic                               cfg_write_en,
  input  logic [pci_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pci_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pci_pkg::*;

  logic [THR_W-1:0]        peak_threshold;
  logic [SCALE_W-1:0]      charge_scale;
  logic                    snap_valid;
  logic                    snap_free;
  frame_snap_t             snap;
  logic signed [PFX_W-1:0] pedestal_sum;

  // Configuration registers; a write takes effect at the next edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= THRESHOLD_RESET;
      charge_scale   <= SCALE_RESET;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_PEAK_THRESHOLD: peak_threshold <= cfg_data[THR_W-1:0];
        REG_CHARGE_SCALE:   charge_scale   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Running frame state, departure check and prefix sums.
  pci_frame u_frame (
    .clk            (clk),
    .rst            (rst),
    .samples        (samples),
    .peak_threshold (peak_threshold),
    .snap_free      (snap_free),
    .snap_valid     (snap_valid),
    .snap           (snap),
    .pedestal_sum   (pedestal_sum)
  );

  // Pedestal subtraction, scaling and the result register.
  pci_charge u_charge (
    .clk          (clk),
    .rst          (rst),
    .snap_valid   (snap_valid),
    .snap         (snap),
    .pedestal_sum (pedestal_sum),
    .charge_scale (charge_scale),
    .snap_free    (snap_free),
    .results      (results)
  );

  // The pipeline is empty right after reset.
  a_no_result_after_reset: assert property (@(posedge clk) rst |=> !results.valid)
    else $error("result beat presented right after reset");

  // With the input register empty after reset, a sample can be taken at once.
  a_ready_after_reset: assert property (@(posedge clk) rst |=> samples.ready)
    else $error("sample channel not ready after reset");

  // A skipped frame carries no charge.
  a_skipped_zero: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.frame_skipped |-> results.charge == '0)
    else $error("skipped frame with nonzero charge");

  // The negated minimum of 16-bit codes never goes below -32767.
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.pulse_height >= -17'sd32767)
    else $error("pulse height out of range");

endmodule
